### rtl/lti_pkg.sv
// shared constants for the line / triangle intersection block
`timescale 1ns / 1ps
`default_nettype none

package lti_pkg;

    // default coordinate width
    localparam int COORD_WIDTH_DEF = 16;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Z = 3'd5;

    // cosine threshold 0.001, squared and inverted
    localparam int COS_SCALE   = 1000000;
    localparam int COS_SCALE_W = 21;

    // operand slice width of the pipelined multiplier
    localparam int MUL_CHUNK = 18;

endpackage

`default_nettype wire

### rtl/lti_mul.sv
// two-stage signed multiplier, wide operand cut into slices
`timescale 1ns / 1ps
`default_nettype none

module lti_mul #(
    parameter int AW = 16,
    parameter int BW = 16,
    parameter int CW = lti_pkg::MUL_CHUNK
) (
    input  logic                 i_clk,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0] o_p
);

    localparam int K   = (AW + CW - 1) / CW;
    localparam int XW  = K * CW;
    localparam int PPW = CW + BW + 1;
    localparam int SW  = XW + BW + 1;

    logic signed [XW-1:0]    a_ext;
    logic signed [PPW-1:0]   n_pp [K];
    logic signed [PPW-1:0]   r_pp [K];
    logic signed [SW-1:0]    n_acc;
    logic signed [AW+BW-1:0] r_p;

    assign a_ext = XW'(i_a);

    // partial products: low slices unsigned, top slice signed
    always_comb begin
        for (int j = 0; j < K; j++) begin
            if (j == K - 1) begin
                n_pp[j] = $signed(a_ext[j*CW +: CW]) * i_b;
            end else begin
                n_pp[j] = $signed({1'b0, a_ext[j*CW +: CW]}) * i_b;
            end
        end
    end

    always_comb begin
        n_acc = '0;
        for (int j = 0; j < K; j++) begin
            n_acc = n_acc + (SW'(r_pp[j]) <<< (j * CW));
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp <= n_pp;
        r_p  <= n_acc[AW+BW-1:0];
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

### rtl/line_triangle_intersect.sv
// top level: pipelined test of one configured line against a triangle stream
//
// usage
//   the line is set through the write port: i_cfg_we, i_cfg_idx, i_cfg_data
//   (origin x, y, z at indexes 0..2, direction x, y, z at 3..5, others ignored)
//   write it only while no transaction is in flight
//   a triangle transaction is taken at a rising edge with i_start high and
//   o_busy low; o_busy is always low, so one triangle can enter every cycle
//   each triangle gives exactly one result: o_valid is high for one cycle with
//   o_hit and o_mesh_end_out, all three registered at the end of the valid chain
//   throughput is one triangle per cycle; the pipeline depth is set by
//   five levels of two-stage sliced multipliers plus the add stages between
//   o_hit marks a strict inside crossing of the infinite line; parallel
//   (cosine below 0.001), degenerate triangles and a zero direction give 0
//   the consumer ORs o_hit over a run up to o_mesh_end_out
//   reset clears the line registers and drops every transaction in flight
//   the receiver cannot stall, results are never held back
`timescale 1ns / 1ps
`default_nettype none

module line_triangle_intersect #(
    parameter int COORD_WIDTH = lti_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [lti_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]             i_cfg_data,
    // triangle transaction
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [COORD_WIDTH-1:0]      i_a_x,
    input  logic signed [COORD_WIDTH-1:0]      i_a_y,
    input  logic signed [COORD_WIDTH-1:0]      i_a_z,
    input  logic signed [COORD_WIDTH-1:0]      i_b_x,
    input  logic signed [COORD_WIDTH-1:0]      i_b_y,
    input  logic signed [COORD_WIDTH-1:0]      i_b_z,
    input  logic signed [COORD_WIDTH-1:0]      i_c_x,
    input  logic signed [COORD_WIDTH-1:0]      i_c_y,
    input  logic signed [COORD_WIDTH-1:0]      i_c_z,
    input  logic                               i_mesh_end,
    // result
    output logic                               o_valid,
    output logic                               o_hit,
    output logic                               o_mesh_end_out
);

    localparam int W     = COORD_WIDTH;
    localparam int EW    = W + 1;                 // vertex differences
    localparam int NW    = 2 * EW + 1;            // normal components
    localparam int DENW  = NW + W + 2;            // N.D
    localparam int NNW   = 2 * NW + 2;            // N.N
    localparam int NUMW  = NW + EW + 3;           // -N.(O-A)
    localparam int DDW   = 2 * W + 2;             // D.D
    localparam int RW    = ((DENW + EW > NUMW + W) ? DENW + EW : NUMW + W) + 1;
    localparam int CRW   = RW + EW + 1;           // edge cross products
    localparam int FW    = CRW + NW + 2;          // edge test values
    localparam int D2W   = 2 * DENW;
    localparam int CSW   = lti_pkg::COS_SCALE_W;
    localparam int LHSW  = D2W + CSW;
    localparam int RHSW  = NNW + DDW;
    localparam int CMPW  = ((LHSW > RHSW) ? LHSW : RHSW) + 1;
    localparam int LAT   = 18;
    localparam logic signed [CSW-1:0] COS_K = CSW'(lti_pkg::COS_SCALE);

    // line registers
    logic signed [W-1:0]   r_org [3];
    logic signed [W-1:0]   r_dir [3];
    logic signed [DDW-1:0] r_dd;

    // valid and mesh mark travel with the data
    logic r_vld [17];
    logic r_me  [17];

    logic signed [W-1:0]    r_s0_v [3][3];
    logic signed [EW-1:0]   r_s1_ac [3];
    logic signed [EW-1:0]   r_edd [10][3][3];
    logic signed [EW-1:0]   r_ovd [7][3][3];
    logic signed [NW-1:0]   r_nd [10][3];
    logic signed [DENW-1:0] r_s7_den;
    logic signed [NNW-1:0]  r_s7_nn;
    logic signed [NUMW-1:0] r_s7_num;
    logic                   r_dneg [8];
    logic                   r_dnz [9];
    logic signed [RW-1:0]   r_s10_r [3][3];
    logic signed [D2W-1:0]  r_s10_d2;
    logic signed [RHSW-1:0] r_s10_rhs;
    logic signed [RHSW-1:0] r_rhs11;
    logic signed [RHSW-1:0] r_rhs12;
    logic                   r_par [4];
    logic signed [CRW-1:0]  r_s13_c [3][3];
    logic                   r_s16_ok [3];

    logic signed [2*EW-1:0]    w_np [3];
    logic signed [2*EW-1:0]    w_nq [3];
    logic signed [NW+W-1:0]    w_dp [3];
    logic signed [2*NW-1:0]    w_nnp [3];
    logic signed [NW+EW-1:0]   w_nup [3];
    logic signed [2*DENW-1:0]  w_d2;
    logic signed [RHSW-1:0]    w_rhs;
    logic signed [DENW+EW-1:0] w_rp [3][3];
    logic signed [NUMW+W-1:0]  w_rq [3];
    logic signed [LHSW-1:0]    w_lhs;
    logic signed [RW+EW-1:0]   w_cp [3][3];
    logic signed [RW+EW-1:0]   w_cq [3][3];
    logic signed [CRW+NW-1:0]  w_fp [3][3];
    logic signed [FW-1:0]      n_f [3];

    assign o_busy = 1'b0;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '{default: '0};
            r_dir <= '{default: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lti_pkg::REG_ORIGIN_X:    r_org[0] <= i_cfg_data;
                lti_pkg::REG_ORIGIN_Y:    r_org[1] <= i_cfg_data;
                lti_pkg::REG_ORIGIN_Z:    r_org[2] <= i_cfg_data;
                lti_pkg::REG_DIRECTION_X: r_dir[0] <= i_cfg_data;
                lti_pkg::REG_DIRECTION_Y: r_dir[1] <= i_cfg_data;
                lti_pkg::REG_DIRECTION_Z: r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // |D|^2 follows the direction registers, settled long before it is used
    always_ff @(posedge i_clk) begin
        r_dd <= DDW'(r_dir[0]) * DDW'(r_dir[0]) + DDW'(r_dir[1]) * DDW'(r_dir[1])
              + DDW'(r_dir[2]) * DDW'(r_dir[2]);
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld          <= '{default: 1'b0};
            o_valid        <= 1'b0;
            o_hit          <= 1'b0;
        end else begin
            r_vld[0] <= i_start && !o_busy;
            for (int s = 1; s < 17; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            o_valid <= r_vld[16];
            o_hit   <= r_vld[16] && r_s16_ok[0] && r_s16_ok[1] && r_s16_ok[2]
                       && r_par[3] && r_dnz[8];
        end
    end

    // stage 0 capture, stage 1 differences, delay lines
    always_ff @(posedge i_clk) begin
        r_me[0] <= i_mesh_end;
        for (int s = 1; s < 17; s++) begin
            r_me[s] <= r_me[s-1];
        end
        o_mesh_end_out <= r_me[16];

        r_s0_v[0][0] <= i_a_x;
        r_s0_v[0][1] <= i_a_y;
        r_s0_v[0][2] <= i_a_z;
        r_s0_v[1][0] <= i_b_x;
        r_s0_v[1][1] <= i_b_y;
        r_s0_v[1][2] <= i_b_z;
        r_s0_v[2][0] <= i_c_x;
        r_s0_v[2][1] <= i_c_y;
        r_s0_v[2][2] <= i_c_z;

        for (int k = 0; k < 3; k++) begin
            r_s1_ac[k] <= EW'(r_s0_v[2][k]) - EW'(r_s0_v[0][k]);
            // edges a->b, b->c, c->a
            r_edd[0][0][k] <= EW'(r_s0_v[1][k]) - EW'(r_s0_v[0][k]);
            r_edd[0][1][k] <= EW'(r_s0_v[2][k]) - EW'(r_s0_v[1][k]);
            r_edd[0][2][k] <= EW'(r_s0_v[0][k]) - EW'(r_s0_v[2][k]);
            for (int i = 0; i < 3; i++) begin
                r_ovd[0][i][k] <= EW'(r_org[k]) - EW'(r_s0_v[i][k]);
            end
        end
        for (int s = 1; s < 10; s++) begin
            r_edd[s] <= r_edd[s-1];
            r_nd[s]  <= r_nd[s-1];
        end
        for (int s = 1; s < 7; s++) begin
            r_ovd[s] <= r_ovd[s-1];
        end

        // normal N = (C - A) x (B - A)
        for (int k = 0; k < 3; k++) begin
            r_nd[0][k] <= NW'(w_np[k]) - NW'(w_nq[k]);
        end

        // plane terms
        r_s7_den <= DENW'(w_dp[0]) + DENW'(w_dp[1]) + DENW'(w_dp[2]);
        r_s7_nn  <= NNW'(w_nnp[0]) + NNW'(w_nnp[1]) + NNW'(w_nnp[2]);
        r_s7_num <= -(NUMW'(w_nup[0]) + NUMW'(w_nup[1]) + NUMW'(w_nup[2]));

        r_dneg[0] <= r_s7_den[DENW-1];
        r_dnz[0]  <= (r_s7_den != '0);
        for (int s = 1; s < 8; s++) begin
            r_dneg[s] <= r_dneg[s-1];
        end
        for (int s = 1; s < 9; s++) begin
            r_dnz[s] <= r_dnz[s-1];
        end

        // scaled hit point relative to each vertex
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                r_s10_r[i][k] <= RW'(w_rp[i][k]) + RW'(w_rq[k]);
            end
        end
        r_s10_d2  <= w_d2;
        r_s10_rhs <= w_rhs;
        r_rhs11   <= r_s10_rhs;
        r_rhs12   <= r_rhs11;

        // parallel test: 1e6 * den^2 >= |N|^2 * |D|^2
        r_par[0] <= CMPW'(w_lhs) >= CMPW'(r_rhs12);
        for (int s = 1; s < 4; s++) begin
            r_par[s] <= r_par[s-1];
        end

        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                r_s13_c[i][k] <= CRW'(w_cp[i][k]) - CRW'(w_cq[i][k]);
            end
        end

        // edge value must carry the sign of den, strictly
        for (int i = 0; i < 3; i++) begin
            r_s16_ok[i] <= (n_f[i] != '0) && (n_f[i][FW-1] == r_dneg[7]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f[i] = FW'(w_fp[i][0]) + FW'(w_fp[i][1]) + FW'(w_fp[i][2]);
        end
    end

    // multiplier levels
    for (genvar gk = 0; gk < 3; gk++) begin : g_axis
        // normal
        lti_mul #(.AW(EW), .BW(EW)) u_np (
            .i_clk (i_clk),
            .i_a   (r_s1_ac[(gk+1)%3]),
            .i_b   (r_edd[0][0][(gk+2)%3]),
            .o_p   (w_np[gk])
        );
        lti_mul #(.AW(EW), .BW(EW)) u_nq (
            .i_clk (i_clk),
            .i_a   (r_s1_ac[(gk+2)%3]),
            .i_b   (r_edd[0][0][(gk+1)%3]),
            .o_p   (w_nq[gk])
        );
        // plane dot products
        lti_mul #(.AW(NW), .BW(W)) u_den (
            .i_clk (i_clk),
            .i_a   (r_nd[0][gk]),
            .i_b   (r_dir[gk]),
            .o_p   (w_dp[gk])
        );
        lti_mul #(.AW(NW), .BW(NW)) u_nn (
            .i_clk (i_clk),
            .i_a   (r_nd[0][gk]),
            .i_b   (r_nd[0][gk]),
            .o_p   (w_nnp[gk])
        );
        lti_mul #(.AW(NW), .BW(EW)) u_num (
            .i_clk (i_clk),
            .i_a   (r_nd[0][gk]),
            .i_b   (r_ovd[3][0][gk]),
            .o_p   (w_nup[gk])
        );
        lti_mul #(.AW(NUMW), .BW(W)) u_rq (
            .i_clk (i_clk),
            .i_a   (r_s7_num),
            .i_b   (r_dir[gk]),
            .o_p   (w_rq[gk])
        );
        for (genvar gi = 0; gi < 3; gi++) begin : g_vtx
            lti_mul #(.AW(DENW), .BW(EW)) u_rp (
                .i_clk (i_clk),
                .i_a   (r_s7_den),
                .i_b   (r_ovd[6][gi][gk]),
                .o_p   (w_rp[gi][gk])
            );
            lti_mul #(.AW(RW), .BW(EW)) u_cp (
                .i_clk (i_clk),
                .i_a   (r_s10_r[gi][(gk+1)%3]),
                .i_b   (r_edd[9][gi][(gk+2)%3]),
                .o_p   (w_cp[gi][gk])
            );
            lti_mul #(.AW(RW), .BW(EW)) u_cq (
                .i_clk (i_clk),
                .i_a   (r_s10_r[gi][(gk+2)%3]),
                .i_b   (r_edd[9][gi][(gk+1)%3]),
                .o_p   (w_cq[gi][gk])
            );
            lti_mul #(.AW(CRW), .BW(NW)) u_fp (
                .i_clk (i_clk),
                .i_a   (r_s13_c[gi][gk]),
                .i_b   (r_nd[9][gk]),
                .o_p   (w_fp[gi][gk])
            );
        end
    end

    lti_mul #(.AW(DENW), .BW(DENW)) u_d2 (
        .i_clk (i_clk),
        .i_a   (r_s7_den),
        .i_b   (r_s7_den),
        .o_p   (w_d2)
    );

    lti_mul #(.AW(NNW), .BW(DDW)) u_rhs (
        .i_clk (i_clk),
        .i_a   (r_s7_nn),
        .i_b   (r_dd),
        .o_p   (w_rhs)
    );

    lti_mul #(.AW(D2W), .BW(CSW)) u_lhs (
        .i_clk (i_clk),
        .i_a   (r_s10_d2),
        .i_b   (COS_K),
        .o_p   (w_lhs)
    );

    // checks
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid)
        else $error("accepted transaction gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, LAT))
        else $error("result without accepted transaction");

    a_mesh_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_mesh_end_out == $past(i_mesh_end, LAT)))
        else $error("mesh mark out of step");

    a_hit_qualified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_hit)
        else $error("hit outside result strobe");

endmodule

`default_nettype wire

### bench/line_triangle_intersect_chk.sv
// checker for the line / triangle intersection block: mirrors the line, predicts and compares
`timescale 1ns / 1ps
`default_nettype none

module line_triangle_intersect_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lti_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [15:0]                         i_cfg_data,
    input  logic                                i_start,
    input  logic                                i_busy,
    input  logic signed [15:0]                  i_a_x,
    input  logic signed [15:0]                  i_a_y,
    input  logic signed [15:0]                  i_a_z,
    input  logic signed [15:0]                  i_b_x,
    input  logic signed [15:0]                  i_b_y,
    input  logic signed [15:0]                  i_b_z,
    input  logic signed [15:0]                  i_c_x,
    input  logic signed [15:0]                  i_c_y,
    input  logic signed [15:0]                  i_c_z,
    input  logic                                i_mesh_end,
    input  logic                                i_valid,
    input  logic                                i_hit,
    input  logic                                i_mesh_end_out,
    output int                                  o_errors,
    output int                                  o_outstanding
);

    typedef logic signed [255:0] big_t;
    typedef struct {
        big_t x;
        big_t y;
        big_t z;
    } vec_t;
    typedef struct packed {
        logic hit;
        logic mesh_end;
    } verdict_t;

    logic signed [15:0] line_org [3];
    logic signed [15:0] line_dir [3];
    verdict_t           verdicts_due [$];

    function automatic vec_t mkvec(logic signed [15:0] x, logic signed [15:0] y,
                                   logic signed [15:0] z);
        vec_t v;
        v.x = big_t'(x);
        v.y = big_t'(y);
        v.z = big_t'(z);
        return v;
    endfunction

    function automatic vec_t vdiff(vec_t a, vec_t b);
        vec_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic vec_t vcross(vec_t a, vec_t b);
        vec_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic big_t vdot(vec_t a, vec_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    // exact strict-inside test, division folded into the sign of n.d
    function automatic logic crossing(vec_t va, vec_t vb, vec_t vc, vec_t org, vec_t dir);
        vec_t corner [3];
        vec_t nrm, ov, edg, r;
        big_t den, num, s;
        logic in_tri;
        corner[0] = va;
        corner[1] = vb;
        corner[2] = vc;
        nrm = vcross(vdiff(vc, va), vdiff(vb, va));
        den = vdot(nrm, dir);
        if (den == 0) return 1'b0;
        // parallel when cos^2 below 1e-6
        if (den * den * big_t'(lti_pkg::COS_SCALE) < vdot(nrm, nrm) * vdot(dir, dir))
            return 1'b0;
        num = -vdot(nrm, vdiff(org, va));
        in_tri = 1'b1;
        for (int i = 0; i < 3; i++) begin
            ov  = vdiff(org, corner[i]);
            edg = vdiff(corner[(i + 1) % 3], corner[i]);
            r.x = den * ov.x + num * dir.x;
            r.y = den * ov.y + num * dir.y;
            r.z = den * ov.z + num * dir.z;
            s = vdot(vcross(r, edg), nrm);
            if (den > 0 ? !(s > 0) : !(s < 0)) in_tri = 1'b0;
        end
        return in_tri;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t chk: %s", $realtime, what);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_outstanding = verdicts_due.size();

    always @(posedge i_clk) begin
        verdict_t got, want;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                line_org[i] = '0;
                line_dir[i] = '0;
            end
            verdicts_due.delete();
        end else begin
            // result side first, then newly accepted transaction
            if (i_valid) begin
                got.hit      = i_hit;
                got.mesh_end = i_mesh_end_out;
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result with nothing outstanding");
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
                    if (got.mesh_end !== want.mesh_end)
                        report_mismatch($sformatf("mesh_end_out %b, want %b",
                                                  got.mesh_end, want.mesh_end));
                end
            end
            if (i_start && !i_busy) begin
                want.hit = crossing(mkvec(i_a_x, i_a_y, i_a_z), mkvec(i_b_x, i_b_y, i_b_z),
                                    mkvec(i_c_x, i_c_y, i_c_z),
                                    mkvec(line_org[0], line_org[1], line_org[2]),
                                    mkvec(line_dir[0], line_dir[1], line_dir[2]));
                want.mesh_end = i_mesh_end;
                verdicts_due.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lti_pkg::REG_ORIGIN_X:    line_org[0] = i_cfg_data;
                    lti_pkg::REG_ORIGIN_Y:    line_org[1] = i_cfg_data;
                    lti_pkg::REG_ORIGIN_Z:    line_org[2] = i_cfg_data;
                    lti_pkg::REG_DIRECTION_X: line_dir[0] = i_cfg_data;
                    lti_pkg::REG_DIRECTION_Y: line_dir[1] = i_cfg_data;
                    lti_pkg::REG_DIRECTION_Z: line_dir[2] = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### bench/line_triangle_intersect_tb.sv
// testbench top for the line / triangle intersection block: stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none

module line_triangle_intersect_tb;

    // pipeline depth plus margin, waited out before any line write
    localparam int DRAIN_CYCLES = 24;
    localparam int IDX_W        = lti_pkg::CFG_IDX_W;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [IDX_W-1:0]       i_cfg_idx;
    logic [15:0]            i_cfg_data;
    logic                   i_start;
    logic                   o_busy;
    logic signed [15:0]     i_a_x, i_a_y, i_a_z;
    logic signed [15:0]     i_b_x, i_b_y, i_b_z;
    logic signed [15:0]     i_c_x, i_c_y, i_c_z;
    logic                   i_mesh_end;
    logic                   o_valid;
    logic                   o_hit;
    logic                   o_mesh_end_out;
    int                     mismatches;
    int                     outstanding;

    // mirror of the line origin so triangles can be placed around it
    int                     org_now [3];
    int                     idle_pct;

    line_triangle_intersect #(.COORD_WIDTH(16)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_a_x          (i_a_x),
        .i_a_y          (i_a_y),
        .i_a_z          (i_a_z),
        .i_b_x          (i_b_x),
        .i_b_y          (i_b_y),
        .i_b_z          (i_b_z),
        .i_c_x          (i_c_x),
        .i_c_y          (i_c_y),
        .i_c_z          (i_c_z),
        .i_mesh_end     (i_mesh_end),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_mesh_end_out (o_mesh_end_out)
    );

    line_triangle_intersect_chk chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_a_x          (i_a_x),
        .i_a_y          (i_a_y),
        .i_a_z          (i_a_z),
        .i_b_x          (i_b_x),
        .i_b_y          (i_b_y),
        .i_b_z          (i_b_z),
        .i_c_x          (i_c_x),
        .i_c_y          (i_c_y),
        .i_c_z          (i_c_z),
        .i_mesh_end     (i_mesh_end),
        .i_valid        (o_valid),
        .i_hit          (o_hit),
        .i_mesh_end_out (o_mesh_end_out),
        .o_errors       (mismatches),
        .o_outstanding  (outstanding)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #4ms;
        $display("line_triangle_intersect_tb: done, errors");
        $finish;
    end

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    // present one triangle and hold it until the block takes it
    task automatic send_tri(int ax, int ay, int az, int bx, int by, int bz,
                            int cx, int cy, int cz, logic me);
        i_a_x      <= clamp16(ax);
        i_a_y      <= clamp16(ay);
        i_a_z      <= clamp16(az);
        i_b_x      <= clamp16(bx);
        i_b_y      <= clamp16(by);
        i_b_z      <= clamp16(bz);
        i_c_x      <= clamp16(cx);
        i_c_y      <= clamp16(cy);
        i_c_z      <= clamp16(cz);
        i_mesh_end <= me;
        i_start    <= 1'b1;
        // busy is tied low, so its value at the falling edge holds at the next rise
        forever begin
            @(negedge i_clk);
            if (!o_busy) break;
        end
        @(posedge i_clk);
        // random sender gaps between transactions
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every transaction has come out
    task automatic wait_empty();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // the caller drops the write enable after its last write
    task automatic write_reg(logic [IDX_W-1:0] idx, int val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[15:0];
        @(posedge i_clk);
    endtask

    task automatic set_line(int ox, int oy, int oz, int dx, int dy, int dz);
        write_reg(lti_pkg::REG_ORIGIN_X, ox);
        write_reg(lti_pkg::REG_ORIGIN_Y, oy);
        write_reg(lti_pkg::REG_ORIGIN_Z, oz);
        write_reg(lti_pkg::REG_DIRECTION_X, dx);
        write_reg(lti_pkg::REG_DIRECTION_Y, dy);
        write_reg(lti_pkg::REG_DIRECTION_Z, dz);
        i_cfg_we   <= 1'b0;
        org_now[0] = 32'(signed'(ox[15:0]));
        org_now[1] = 32'(signed'(oy[15:0]));
        org_now[2] = 32'(signed'(oz[15:0]));
    endtask

    function automatic int rnd_s16();
        return 32'(signed'(16'($urandom)));
    endfunction

    function automatic int rnd_off(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // mostly triangles placed around the origin of the line, some pure noise
    task automatic send_random();
        int span;
        int p [9];
        span = (($urandom_range(0, 3) == 0) ? 8 : ($urandom_range(0, 1) ? 256 : 4096));
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < 9; i++) p[i] = rnd_s16();
        end else begin
            for (int i = 0; i < 9; i++) p[i] = org_now[i % 3] + rnd_off(span);
        end
        send_tri(p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8], 1'($urandom));
    endtask

    initial begin
        int pcts [6] = '{0, 75, 18, 0, 75, 18};
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_start    = 1'b0;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} = '0;
        i_mesh_end = 1'b0;
        idle_pct   = 0;
        org_now    = '{0, 0, 0};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero direction straight after reset: never a hit
        send_tri(-512, -512, 256, 512, -512, 256, 0, 512, 256, 1'b0);
        wait_empty();

        // line along z through the origin
        set_line(0, 0, 0, 0, 0, 256);
        send_tri(-512, -512, 256, 512, -512, 256, 0, 512, 256, 1'b0);
        send_tri(-512, -512, 256, 0, 512, 256, 512, -512, 256, 1'b1);
        // crossing behind the origin still counts
        send_tri(-512, -512, -900, 512, -512, -900, 0, 512, -900, 1'b0);
        // line through an edge and through a vertex
        send_tri(0, -256, 0, 0, 256, 0, 512, 0, 0, 1'b0);
        send_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b1);
        // degenerate: collinear and all corners equal
        send_tri(-256, -256, 0, 0, 0, 0, 256, 256, 0, 1'b0);
        send_tri(100, 100, 100, 100, 100, 100, 100, 100, 100, 1'b0);
        // plane containing the line, then one only just off parallel
        send_tri(0, 0, 0, 256, 0, 0, 0, 0, 256, 1'b1);
        send_tri(-256, -256, 0, 256, -256, 0, 0, 256, 32767, 1'b0);
        send_tri(-256, -256, 0, 256, -256, 1, 0, 256, 600, 1'b0);
        // extremes of the coordinate range
        send_tri(-32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0, 1'b1);
        send_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                 32767, 32767, 32767, 1'b0);
        send_tri(32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768, 1'b1);
        send_tri(-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767, 1'b0);
        wait_empty();

        // extreme line, unused register indexes written too
        set_line(-32768, 32767, -32768, 32767, -32768, 32767);
        write_reg(IDX_W'(6), rnd_s16());
        write_reg(IDX_W'(7), rnd_s16());
        i_cfg_we <= 1'b0;
        send_tri(-32768, 32767, -32000, -32000, 32767, -32768, -32768, 32000, -32768, 1'b1);
        send_tri(32767, 32767, 32767, -32768, -32768, 32767, 0, 0, -32768, 1'b0);
        wait_empty();

        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = pcts[ph];
            case (ph)
                2: set_line(32767, -32768, 32767, -32768, -32768, -32768);
                4: set_line(-32768, -32768, -32768, 32767, 32767, 32767);
                default: set_line(rnd_off(8192), rnd_off(8192), rnd_off(8192),
                                  rnd_s16(), rnd_s16(), rnd_s16());
            endcase
            for (int n = 0; n < 290; n++) begin
                // one hold-off until the pipeline has emptied
                if (ph == 1 && n == 145) begin
                    i_start <= 1'b0;
                    @(posedge i_clk);
                    while (outstanding != 0) @(posedge i_clk);
                end
                send_random();
            end
            wait_empty();
        end

        if (mismatches == 0) begin
            $display("line_triangle_intersect_tb: done, clean");
        end else begin
            $display("line_triangle_intersect_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/lti_pkg.sv
rtl/lti_mul.sv
rtl/line_triangle_intersect.sv
bench/line_triangle_intersect_chk.sv
bench/line_triangle_intersect_tb.sv
